// File: hdl/dlfs_pkg.sv
// Shared constants, types and helpers for the dump line field splitter.
package dlfs_pkg;

   // Default depth of the held whitespace buffer
   localparam int DEF_SPACE_DEPTH = 16;

   // Escape name storage
   localparam int          NAME_MAX_LEN  = 5;
   localparam logic [2:0]  NAME_TOO_LONG = 3'd6;

   // Special characters
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FLUSH_RD,
      ST_FLUSH_WR,
      ST_EMIT_CHAR,
      ST_EMIT_END
   } state_type;

   // What the decoded word asks for
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_CHAR,
      ACT_END
   } action_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic flush_read;
      logic flush_emit;
      logic emit_char;
      logic emit_end;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type kind;
      logic       flush_needed;
      logic       flush_last;
      logic       out_free;
   } dp_stat_type;

   // Whitespace: space, tab, CR, LF, VT, FF
   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
             (c == CH_VT) || (c == CH_FF);
   endfunction

endpackage

// File: hdl/dlfs_ctrl.sv
// Controller state machine of the dump line field splitter.
module dlfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output dlfs_pkg::dp_cmd_type cmd,
   input  dlfs_pkg::dp_stat_type stat
);
   import dlfs_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (stat.kind)
               ACT_END:  state_in = ST_EMIT_END;
               ACT_CHAR: state_in = stat.flush_needed ? ST_FLUSH_RD : ST_EMIT_CHAR;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH_WR;
         end
         ST_FLUSH_WR: begin
            if (stat.out_free) state_in = stat.flush_last ? ST_EMIT_CHAR : ST_FLUSH_RD;
         end
         ST_EMIT_CHAR, ST_EMIT_END: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            cmd.finish = (stat.kind == ACT_NONE);
         end
         ST_FLUSH_RD: begin
            cmd.flush_read = 1'b1;
         end
         ST_FLUSH_WR: begin
            cmd.flush_emit = stat.out_free;
         end
         ST_EMIT_CHAR: begin
            cmd.emit_char = stat.out_free;
            cmd.finish    = stat.out_free;
         end
         ST_EMIT_END: begin
            cmd.emit_end = stat.out_free;
            cmd.finish   = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hdl/dlfs_datapath.sv
// Datapath of the dump line field splitter: escape name, whitespace buffer, output word.
module dlfs_datapath #(
   parameter int SPACE_DEPTH = dlfs_pkg::DEF_SPACE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dlfs_pkg::dp_cmd_type  cmd,
   output dlfs_pkg::dp_stat_type stat,
   input  logic [7:0]            req_char_in,
   input  logic                  req_last_in_line,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_has_char,
   output logic                  rsp_value_end,
   output logic                  rsp_ws_overflow
);
   import dlfs_pkg::*;

   localparam int CW = $clog2(SPACE_DEPTH + 2);
   localparam int IW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);

   // Captured word
   logic [7:0] char_ff;
   logic       last_ff;

   // Line state
   logic          in_escape_ff;
   logic [7:0]    name_ff [NAME_MAX_LEN];
   logic [2:0]    esc_len_ff;
   logic          seen_text_ff;
   logic [CW-1:0] pend_cnt_ff;
   logic          overflow_ff;

   // Whitespace buffer and flush control
   logic [7:0]    pend_mem [SPACE_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [CW-1:0] held_ff;
   logic [CW-1:0] ptr_ff;
   logic [7:0]    val_ff;

   // Output word
   logic       out_valid_ff;
   logic [7:0] out_char_ff;
   logic       out_has_ff;
   logic       out_end_ff;
   logic       out_ovf_ff;

   // Decode signals
   logic          esc_close;
   logic          ins_valid;
   logic [7:0]    ins_char;
   logic          vc_valid;
   logic [7:0]    vc_char;
   logic          vc_ws;
   logic          is_end;
   logic [CW-1:0] held_in;
   logic          out_free;

   // Escape name lookup
   always_comb begin
      ins_valid = 1'b0;
      ins_char  = 8'h00;
      if (esc_len_ff == 3'd3 && name_ff[0] == "E" && name_ff[1] == "S" &&
          name_ff[2] == "C") begin
         ins_valid = 1'b1;
         ins_char  = CH_CARET;
      end else if (esc_len_ff == 3'd5 && name_ff[0] == "T" && name_ff[1] == "I" &&
                   name_ff[2] == "L" && name_ff[3] == "D" && name_ff[4] == "E") begin
         ins_valid = 1'b1;
         ins_char  = CH_TILDE;
      end else if (esc_len_ff == 3'd2 && name_ff[0] == "C" && name_ff[1] == "R") begin
         ins_valid = 1'b1;
         ins_char  = CH_CR;
      end else if (esc_len_ff == 3'd2 && name_ff[0] == "L" && name_ff[1] == "F") begin
         ins_valid = 1'b1;
         ins_char  = CH_LF;
      end
   end

   // Classify the captured word
   always_comb begin
      esc_close = in_escape_ff && (char_ff == CH_TILDE);
      is_end    = !in_escape_ff && (char_ff == CH_CARET);
      vc_valid  = (esc_close && ins_valid) ||
                  (!in_escape_ff && char_ff != CH_CARET && char_ff != CH_CR &&
                   char_ff != CH_LF && char_ff != CH_TILDE);
      vc_char   = esc_close ? ins_char : char_ff;
      vc_ws     = is_ws(vc_char);
      held_in   = (pend_cnt_ff > DEPTH_C) ? DEPTH_C : pend_cnt_ff;
      out_free  = !out_valid_ff || !rsp_stall;
   end

   // Status to controller
   always_comb begin
      if (is_end)                  stat.kind = ACT_END;
      else if (vc_valid && !vc_ws) stat.kind = ACT_CHAR;
      else                         stat.kind = ACT_NONE;
      stat.flush_needed = (held_in != '0);
      stat.flush_last   = ((ptr_ff + CW'(1)) == held_ff);
      stat.out_free     = out_free;
   end

   // Captured word register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff <= req_char_in;
         last_ff <= req_last_in_line;
      end
   end

   // Escape name bytes
   always_ff @(posedge clock) begin
      if (cmd.decode && in_escape_ff && !esc_close && esc_len_ff < 3'(NAME_MAX_LEN)) begin
         name_ff[esc_len_ff] <= char_ff;
      end
   end

   // Whitespace buffer write and flush read
   always_ff @(posedge clock) begin
      if (cmd.decode && vc_valid && vc_ws && seen_text_ff && pend_cnt_ff < DEPTH_C) begin
         pend_mem[pend_cnt_ff[IW-1:0]] <= vc_char;
      end
      if (cmd.flush_read) begin
         rd_data_ff <= pend_mem[ptr_ff[IW-1:0]];
      end
   end

   // Flush bookkeeping and pending character
   always_ff @(posedge clock) begin
      if (cmd.decode && vc_valid && !vc_ws) begin
         held_ff <= held_in;
         val_ff  <= vc_char;
      end
      if (reset) begin
         ptr_ff <= '0;
      end else if (cmd.decode) begin
         ptr_ff <= '0;
      end else if (cmd.flush_emit) begin
         ptr_ff <= ptr_ff + CW'(1);
      end
   end

   // Line state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_escape_ff <= 1'b0;
         esc_len_ff   <= '0;
         seen_text_ff <= 1'b0;
         pend_cnt_ff  <= '0;
         overflow_ff  <= 1'b0;
      end else if (cmd.finish && last_ff) begin
         // line end clears everything
         in_escape_ff <= 1'b0;
         esc_len_ff   <= '0;
         seen_text_ff <= 1'b0;
         pend_cnt_ff  <= '0;
         overflow_ff  <= 1'b0;
      end else if (cmd.decode) begin
         // escape name collection
         if (in_escape_ff && !esc_close) begin
            esc_len_ff <= (esc_len_ff < 3'(NAME_MAX_LEN)) ? esc_len_ff + 3'd1
                                                          : NAME_TOO_LONG;
         end
         if (esc_close) begin
            in_escape_ff <= 1'b0;
            esc_len_ff   <= '0;
         end
         if (!in_escape_ff && char_ff == CH_TILDE) begin
            in_escape_ff <= 1'b1;
            esc_len_ff   <= '0;
         end
         // whitespace is held, text releases it
         if (vc_valid && vc_ws && seen_text_ff) begin
            pend_cnt_ff <= (pend_cnt_ff < DEPTH_C) ? pend_cnt_ff + CW'(1)
                                                   : DEPTH_C + CW'(1);
         end
         if (vc_valid && !vc_ws) begin
            if (pend_cnt_ff > DEPTH_C) overflow_ff <= 1'b1;
            pend_cnt_ff  <= '0;
            seen_text_ff <= 1'b1;
         end
      end else if (cmd.emit_end) begin
         seen_text_ff <= 1'b0;
         pend_cnt_ff  <= '0;
         overflow_ff  <= 1'b0;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.flush_emit || cmd.emit_char || cmd.emit_end) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flush_emit || cmd.emit_char) begin
         out_char_ff <= cmd.flush_emit ? rd_data_ff : val_ff;
         out_has_ff  <= 1'b1;
         out_end_ff  <= 1'b0;
         out_ovf_ff  <= 1'b0;
      end else if (cmd.emit_end) begin
         out_char_ff <= 8'h00;
         out_has_ff  <= 1'b0;
         out_end_ff  <= 1'b1;
         out_ovf_ff  <= overflow_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_has_char    = out_has_ff;
   assign rsp_value_end   = out_end_ff;
   assign rsp_ws_overflow = out_ovf_ff;

endmodule

// File: hdl/dump_line_field_splitter_unit.sv
// Top level of the dump line field splitter.
//
// Input channel req_: one byte of a dump line per word, with req_last_in_line
// on the final byte. A word is taken when req_valid is high and req_stall low.
// Result channel rsp_: one value character per word (rsp_has_char), or a
// value-end marker (rsp_value_end) with rsp_ws_overflow set if inner
// whitespace of that value was dropped.
// A byte that yields nothing is only captured and decoded; a byte that yields
// a character or value end is also loaded into the output register; a
// character that releases held whitespace bytes first sends them out through
// the registered read port of the whitespace buffer (one read, then one
// output load, per held byte). The first result word is loaded after the
// decode state, or after a flush read when held whitespace goes first.
// The output register lets the next byte be taken while a result waits;
// when rsp_stall is high the word holds and the controller waits.
// Reset clears the line state and the output register; the whitespace
// buffer and escape name storage need no clearing.
module dump_line_field_splitter_unit #(
   parameter int SPACE_DEPTH = dlfs_pkg::DEF_SPACE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_last_in_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_value_end,
   output logic       rsp_ws_overflow
);
   import dlfs_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Controller
   dlfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath
   dlfs_datapath #(
      .SPACE_DEPTH (SPACE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_char_in      (req_char_in),
      .req_last_in_line (req_last_in_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_has_char     (rsp_has_char),
      .rsp_value_end    (rsp_value_end),
      .rsp_ws_overflow  (rsp_ws_overflow)
   );

`ifndef SYNTHESIS
   // one byte at a time: after a take the input closes for decode
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken in back-to-back cycles");

   // a result word is either a character or a value end
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_char != rsp_value_end))
      else $error("result word kind is ambiguous");

   // overflow flag only rides on a value end
   a_ovf_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ws_overflow) |-> rsp_value_end)
      else $error("overflow flag on a character word");
`endif

endmodule
